### hdl/pfr_pkg.sv
// Package for the page frame replacement tracker.
// Holds sizes, the controller state type and the structs passed between cells and controller.
// No dependencies.
`default_nettype none
package pfr_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int IDX_W      = $clog2(NUM_FRAMES);
  localparam int RANK_W     = $clog2(NUM_FRAMES);
  localparam int NF_W       = $clog2(NUM_FRAMES + 1);
  localparam int FRAME_W    = 4;
  localparam int EVPAGE_W   = 16;
  localparam int FAULT_W    = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;
  localparam int IN_TDATA_W = ((PAGE_BITS + 7) / 8) * 8;
  localparam int OUT_FLD_W  = 1 + FRAME_W + 1 + EVPAGE_W + FAULT_W;
  localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = CFG_IDX_W'(1);
  localparam logic [NF_W-1:0]      FRAMES_RESET = NF_W'(4);
  localparam logic [RANK_W-1:0]    RANK_MAX = RANK_W'(NUM_FRAMES - 1);
  localparam logic [RANK_W:0]      RANK_NONE = (RANK_W + 1)'(NUM_FRAMES);
  localparam logic                 POLICY_FIFO = 1'b0;
  localparam logic                 MODE_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_UPDATE
  } cmd_op_t;

  typedef struct packed {
    logic                 valid;
    logic [RANK_W-1:0]    rank;
    logic [PAGE_BITS-1:0] page;
  } frame_t;

  typedef struct packed {
    logic                 hit_found;
    logic [IDX_W-1:0]     hit_idx;
    logic [RANK_W-1:0]    hit_rank;
    logic                 empty_found;
    logic [IDX_W-1:0]     empty_idx;
    logic [RANK_W-1:0]    best_rank;
    logic [IDX_W-1:0]     best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } search_t;

  typedef struct packed {
    cmd_op_t              op;
    logic                 shift;
    logic                 write;
    logic [IDX_W-1:0]     f;
    logic [RANK_W:0]      old_rank;
    logic [PAGE_BITS-1:0] page;
    logic [NF_W-1:0]      nf;
  } cmd_t;

endpackage
`default_nettype wire

### hdl/pfr_cell.sv
// One frame cell: stores page, valid bit and recency rank, and one registered stage of
// the search chain. Takes its shifted contents from the next cell. Depends on pfr_pkg.
`default_nettype none
module pfr_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [pfr_pkg::IDX_W-1:0]    idx,
  input  wire  [pfr_pkg::PAGE_BITS-1:0] page_ref,
  input  pfr_pkg::search_t             srch_in,
  input  pfr_pkg::frame_t              nb,
  input  pfr_pkg::cmd_t                cmd,
  output pfr_pkg::frame_t              cur,
  output pfr_pkg::search_t             srch_r
);
  import pfr_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  search_t              srch_nxt;
  frame_t               src;
  logic [NF_W-1:0]      idx_ext;

  assign cur     = '{valid: valid_r, rank: rank_r, page: page_r};
  assign idx_ext = NF_W'(idx);

  always_comb begin
    srch_nxt = srch_in;
    if (!srch_in.hit_found && valid_r && (page_r == page_ref)) begin
      srch_nxt.hit_found = 1'b1;
      srch_nxt.hit_idx   = idx;
      srch_nxt.hit_rank  = rank_r;
    end
    if (!srch_in.empty_found && !valid_r) begin
      srch_nxt.empty_found = 1'b1;
      srch_nxt.empty_idx   = idx;
    end
    if ((idx == '0) || (rank_r > srch_in.best_rank)) begin
      srch_nxt.best_rank = rank_r;
      srch_nxt.best_idx  = idx;
      srch_nxt.best_page = page_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    page_nxt  = page_r;
    src       = cur;
    if (cmd.shift && (idx_ext < (cmd.nf - NF_W'(1)))) begin
      src = nb;
    end
    unique case (cmd.op)
      CMD_CLEAR: begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end
      CMD_UPDATE: begin
        if (idx_ext < cmd.nf) begin
          valid_nxt = src.valid;
          rank_nxt  = src.rank;
          page_nxt  = src.page;
          if (idx == cmd.f) begin
            rank_nxt = '0;
            if (cmd.write) begin
              valid_nxt = 1'b1;
              page_nxt  = cmd.page;
            end
          end else if (src.valid && ({1'b0, src.rank} < cmd.old_rank) &&
                       (src.rank < RANK_MAX)) begin
            rank_nxt = src.rank + RANK_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    srch_r <= srch_nxt;
  end

endmodule
`default_nettype wire

### hdl/pfr_ctrl.sv
// Sequencer of the tracker: takes requests and configuration, waits for the search chain,
// issues the update or clear command and holds the result register. Depends on pfr_pkg.
`default_nettype none
module pfr_ctrl (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [pfr_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire                             in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [pfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [pfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [pfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  pfr_pkg::search_t                srch,
  input  pfr_pkg::frame_t                 head,
  output logic [pfr_pkg::PAGE_BITS-1:0]   page_ref,
  output logic [pfr_pkg::NF_W-1:0]        nf,
  output pfr_pkg::cmd_t                   cmd
);
  import pfr_pkg::*;

  state_t               state_r, state_nxt;
  logic [NF_W-1:0]      cnt_r, cnt_nxt;
  logic                 mode_r;
  logic [PAGE_BITS-1:0] page_r;
  logic                 policy_r;
  logic [CFG_DATA_W-1:0] frames_r;
  logic [FAULT_W-1:0]   faults_r, faults_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                 accept, apply;
  logic                 hit;
  logic [IDX_W-1:0]     f;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;

  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign page_ref   = page_r;

  always_comb begin
    if (frames_r == '0) begin
      nf = NF_W'(1);
    end else if (NF_W'(frames_r) > NF_W'(NUM_FRAMES)) begin
      nf = NF_W'(NUM_FRAMES);
    end else begin
      nf = NF_W'(frames_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SEARCH;
      ST_SEARCH: if (cnt_r == (nf - NF_W'(1))) state_nxt = ST_APPLY;
      ST_APPLY:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    apply     = (state_r == ST_APPLY) && (!out_valid_r || out_tready);
    cnt_nxt   = (state_r == ST_SEARCH) ? cnt_r + NF_W'(1) : '0;
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = CMD_NONE;
    cmd.page     = page_r;
    cmd.nf       = nf;
    faults_nxt   = faults_r;
    hit          = 1'b0;
    f            = '0;
    ev_valid     = 1'b0;
    ev_page      = '0;
    if (apply) begin
      if (mode_r == MODE_CLEAR) begin
        cmd.op     = CMD_CLEAR;
        faults_nxt = '0;
      end else begin
        cmd.op = CMD_UPDATE;
        if (srch.hit_found) begin
          hit          = 1'b1;
          f            = srch.hit_idx;
          cmd.old_rank = {1'b0, srch.hit_rank};
        end else begin
          if (faults_r != '1) faults_nxt = faults_r + FAULT_W'(1);
          cmd.write = 1'b1;
          if (policy_r == POLICY_FIFO) begin
            cmd.shift    = 1'b1;
            f            = IDX_W'(nf - NF_W'(1));
            cmd.old_rank = RANK_NONE;
            ev_valid     = head.valid;
            ev_page      = head.valid ? head.page : '0;
          end else if (srch.empty_found) begin
            f            = srch.empty_idx;
            cmd.old_rank = RANK_NONE;
          end else begin
            f            = srch.best_idx;
            cmd.old_rank = {1'b0, srch.best_rank};
            ev_valid     = 1'b1;
            ev_page      = srch.best_page;
          end
        end
      end
    end
    cmd.f = f;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (apply) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_TDATA_W'({faults_nxt, EVPAGE_W'(ev_page), ev_valid,
                                    FRAME_W'(f), hit});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      policy_r    <= POLICY_FIFO;
      frames_r    <= CFG_DATA_W'(FRAMES_RESET);
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      faults_r    <= faults_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POLICY) policy_r <= cfg_data[0];
        else if (cfg_index == REG_FRAMES) frames_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      mode_r <= in_tuser;
      page_r <= in_tdata[PAGE_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

### hdl/page_frame_replacement_fifo_lru.sv
// Page frame tracker with FIFO or LRU replacement. A request is taken in the idle state,
// then the registered search chain through the frame cells runs in the search state over
// the nf frames in use, and the apply state updates the cells and loads the result.
// A waiting result does not block the next request until its update cycle.
// Synchronous active-low reset empties all frames, zeroes ranks and the fault count,
// and sets FIFO policy with four frames. Depends on pfr_pkg, pfr_cell and pfr_ctrl.
`default_nettype none
module page_frame_replacement_fifo_lru (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [pfr_pkg::IN_TDATA_W-1:0]  in_tdata,   // page
  input  wire                             in_tuser,   // mode
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // hit, frame, evicted_valid, evicted_page, fault_count
  output logic [pfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [pfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [pfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pfr_pkg::*;

  frame_t               cur   [NUM_FRAMES];
  frame_t               nb    [NUM_FRAMES];
  search_t              srch  [NUM_FRAMES];
  search_t              srch_in [NUM_FRAMES];
  search_t              srch_sel;
  logic [PAGE_BITS-1:0] page_ref;
  logic [NF_W-1:0]      nf;
  cmd_t                 cmd;

  assign srch_sel = srch[IDX_W'(nf - NF_W'(1))];

  pfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .srch       (srch_sel),
    .head       (cur[0]),
    .page_ref   (page_ref),
    .nf         (nf),
    .cmd        (cmd)
  );

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign srch_in[i] = '0;
    end else begin : g_rest
      assign srch_in[i] = srch[i-1];
    end
    if (i == NUM_FRAMES - 1) begin : g_last
      assign nb[i] = '0;
    end else begin : g_mid
      assign nb[i] = cur[i+1];
    end

    pfr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (IDX_W'(i)),
      .page_ref (page_ref),
      .srch_in  (srch_in[i]),
      .nb       (nb[i]),
      .cmd      (cmd),
      .cur      (cur[i]),
      .srch_r   (srch[i])
    );
  end

endmodule
`default_nettype wire
